[rtl/mexp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants, types and codes for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // fixed port widths
    localparam int BASE_W = 32;
    localparam int EXP_W  = 32;
    localparam int RES_W  = 31;
    localparam int CFG_W  = 31;

    // parameter defaults
    localparam int EXP_BITS_DEF = 32;
    localparam int MOD_BITS_DEF = 31;

    localparam logic [CFG_W-1:0] MODULUS_RESET = CFG_W'(1000000007);

    // top-level sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_OUT
    } t_state;

    // operation handed to the shared modular multiplier
    typedef enum logic [1:0] {
        OP_RED,
        OP_MUL,
        OP_SQR
    } t_op;

    // status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage
`default_nettype wire

[rtl/mexp_mulmod.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial interleaved modular multiplier: a * b mod m, one bit of b per
// cycle, most significant bit first, one compare-subtract step per cycle.
// ----------------------------------------------------------------------------
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [MOD_BITS-1:0] i_a,
    input  wire logic [BASE_W-1:0]   i_b,
    input  wire logic [MOD_BITS:0]   i_mod,
    output t_mm_status               o_status,
    output logic [MOD_BITS-1:0]      o_prod
);

    localparam int TW  = MOD_BITS + 2;
    localparam int CNW = $clog2(BASE_W);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNW-1:0]      r_cnt;
    logic [MOD_BITS-1:0] r_acc;
    logic [MOD_BITS-1:0] r_a;
    logic [BASE_W-1:0]   r_b;
    logic [MOD_BITS:0]   r_mod;

    logic [TW-1:0]       step_sum;
    logic [TW-1:0]       m1;
    logic [TW-1:0]       m2;
    logic [TW-1:0]       step_red;

    // 2*acc + bit*a stays below 3m, so at most 2m comes off
    always_comb begin
        m1       = TW'(r_mod);
        m2       = TW'(r_mod) << 1;
        step_sum = (TW'(r_acc) << 1) + (r_b[BASE_W-1] ? TW'(r_a) : TW'(0));
        if (step_sum >= m2) begin
            step_red = step_sum - m2;
        end else if (step_sum >= m1) begin
            step_red = step_sum - m1;
        end else begin
            step_red = step_sum;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_cnt == CNW'(0)) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_mod <= i_mod;
            r_cnt <= CNW'(BASE_W - 1);
        end else if (r_busy) begin
            r_acc <= step_red[MOD_BITS-1:0];
            r_b   <= r_b << 1;
            r_cnt <= r_cnt - CNW'(1);
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_prod        = r_acc;

    a_acc_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (MOD_BITS + 1)'(r_acc) < r_mod)
        else $error("mulmod accumulator not reduced");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("mulmod done without a finished run");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("mulmod started while busy");

endmodule
`default_nettype wire

[rtl/modular_exponentiation.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus by right-to-left square-and-multiply, all
// multiplications done in one shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// zero exponent goes straight to the output; otherwise the base is reduced first,
//   then each exponent bit up to the top set bit is a multiply if set, then a square
//   below the top set bit; one item at a time, the input stalls from acceptance
//   until the result enters the output reg
// synchronous active-low reset: idle, output empty, modulus 1000000007
// ----------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEF,
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_modulus,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [BASE_W-1:0] i_base,
    input  wire logic [EXP_W-1:0] i_exponent,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [RES_W-1:0]      o_result
);

    localparam logic [MOD_BITS-1:0] MOD_RST = MODULUS_RESET[MOD_BITS-1:0];

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [MOD_BITS-1:0] r_mod;
    logic [BASE_W-1:0]   r_pw;
    logic [MOD_BITS-1:0] r_res;
    logic [EXP_BITS-1:0] r_exp;
    logic                r_out_valid;
    logic [MOD_BITS-1:0] r_out;

    logic [EXP_BITS-1:0] exp_ld;
    logic [EXP_BITS-1:0] exp_shr;
    logic [MOD_BITS:0]   m_eff;
    logic                in_take;
    logic                out_free;
    logic                mm_start;
    logic [MOD_BITS-1:0] mm_a;
    t_mm_status          mm_status;
    logic [MOD_BITS-1:0] mm_prod;

    assign exp_ld   = EXP_BITS'(i_exponent);
    assign exp_shr  = r_exp >> 1;
    // a modulus of zero wraps at the full width
    assign m_eff    = (r_mod == '0) ? ((MOD_BITS + 1)'(1) << MOD_BITS)
                                    : (MOD_BITS + 1)'(r_mod);
    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // next state and next operation
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = OP_RED;
                    n_state = (exp_ld == '0) ? S_OUT : S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (mm_status.done) begin
                    unique case (r_op)
                        OP_RED: begin
                            n_op    = r_exp[0] ? OP_MUL : OP_SQR;
                            n_state = S_ISSUE;
                        end
                        OP_MUL: begin
                            n_op    = OP_SQR;
                            n_state = (exp_shr == '0) ? S_OUT : S_ISSUE;
                        end
                        default: begin
                            n_op    = exp_shr[0] ? OP_MUL : OP_SQR;
                            n_state = (exp_shr == '0) ? S_OUT : S_ISSUE;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        mm_start    = 1'b0;
        mm_a        = r_pw[MOD_BITS-1:0];
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cfg_ready = 1'b1;
            end
            S_ISSUE: begin
                mm_start = 1'b1;
                unique case (r_op)
                    OP_RED:  mm_a = MOD_BITS'(1);
                    OP_MUL:  mm_a = r_res;
                    default: mm_a = r_pw[MOD_BITS-1:0];
                endcase
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_RED;
            r_mod       <= MOD_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mod <= i_cfg_modulus[MOD_BITS-1:0];
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pw  <= i_base;
            r_exp <= exp_ld;
            r_res <= MOD_BITS'(1);
        end else if (r_state == S_WAIT && mm_status.done) begin
            unique case (r_op)
                OP_RED: begin
                    r_pw <= BASE_W'(mm_prod);
                end
                OP_MUL: begin
                    r_res <= mm_prod;
                end
                default: begin
                    r_pw  <= BASE_W'(mm_prod);
                    r_exp <= exp_shr;
                end
            endcase
        end
        if (r_state == S_OUT && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = RES_W'(r_out);

    mexp_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_a      (mm_a),
        .i_b      (r_pw),
        .i_mod    (m_eff),
        .o_status (mm_status),
        .o_prod   (mm_prod)
    );

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_status.done |-> r_state == S_WAIT)
        else $error("multiplier finished outside of wait state");

    a_idle_unit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !mm_status.busy)
        else $error("multiplier busy while accepting input");

    a_res_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> ((MOD_BITS + 1)'(r_res) < m_eff || r_res == MOD_BITS'(1)))
        else $error("running result not reduced");

    a_issue_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ISSUE |=> mm_status.busy && r_state == S_WAIT)
        else $error("issued operation did not start");

endmodule
`default_nettype wire

[verif/modular_exponentiation_tb.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench for the square-and-multiply exponentiation block: drives
// base/exponent transactions under several modulus settings, predicts each
// result with 64-bit arithmetic and compares every output transaction in order.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb
    import mexp_pkg::*;
;

    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [CFG_W-1:0] MODULUS_MAX = {CFG_W{1'b1}};

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [EXP_W-1:0]  exponent;
        logic [RES_W-1:0]  result;
    } t_power_case;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_modulus;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [BASE_W-1:0]   i_base;
    logic [EXP_W-1:0]    i_exponent;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [RES_W-1:0]    o_result;

    t_power_case         expected_powers[$];
    t_power_case         oldest;
    logic [CFG_W-1:0]    modulus_shadow = MODULUS_RESET;
    int                  mismatches = 0;
    int                  cycle_count = 0;
    int                  hold_cycles = 0;
    bit                  idling_on = 1'b1;

    modular_exponentiation i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_modulus (i_cfg_modulus),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_base        (i_base),
        .i_exponent    (i_exponent),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result      (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // right-to-left square-and-multiply; a zero modulus stands for 2^31
    function automatic logic [RES_W-1:0] power_mod(input logic [BASE_W-1:0] b,
                                                   input logic [EXP_W-1:0] e);
        logic [63:0] m;
        logic [63:0] pw;
        logic [63:0] acc;
        m   = (modulus_shadow == '0) ? (64'd1 << CFG_W) : 64'(modulus_shadow);
        pw  = 64'(b) % m;
        acc = 64'd1;
        if (e != '0) begin
            for (int i = 0; i < EXP_BITS_DEF; i++) begin
                if (e[i]) acc = (acc * pw) % m;
                pw = (pw * pw) % m;
            end
        end
        return acc[RES_W-1:0];
    endfunction

    function automatic logic [BASE_W-1:0] pick_base();
        case ($urandom_range(0, 7))
            0:       return BASE_W'($urandom_range(0, 3));
            1:       return '1;
            2:       return BASE_W'(modulus_shadow) - 1;
            3:       return BASE_W'(modulus_shadow) + BASE_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    // full-width exponents are slow, so some are kept below 256
    function automatic logic [EXP_W-1:0] pick_exponent();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4:          return '0;
            5:          return EXP_W'(1) << $urandom_range(0, EXP_W - 1);
            6:          return '1;
            default:    return EXP_W'($urandom_range(1, 255));
        endcase
    endfunction

    // output side: random stall bursts, or a long hold when asked
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles != 0) begin
                i_out_stall = 1'b1;
                while (hold_cycles != 0) begin
                    @(negedge i_clk);
                    hold_cycles--;
                end
                i_out_stall = 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_powers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %h", o_result);
            end else begin
                oldest = expected_powers.pop_front();
                if (o_result !== oldest.result) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch base %h exponent %h: expected %h got %h",
                                 oldest.base, oldest.exponent, oldest.result, o_result);
                end
            end
        end
    end

    // leaves valid high, unless random idling drops it, so a following transaction is offered back to back
    task automatic send_operands(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e);
        t_power_case entry;
        i_in_valid = 1'b1;
        i_base     = b;
        i_exponent = e;
        do @(posedge i_clk); while (o_in_stall);
        entry = '{base: b, exponent: e, result: power_mod(b, e)};
        expected_powers.insert(expected_powers.size(), entry);
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
    endtask

    task automatic wait_results();
        i_in_valid = 1'b0;
        while (expected_powers.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_modulus(input logic [CFG_W-1:0] value);
        wait_results();
        i_cfg_valid   = 1'b1;
        i_cfg_modulus = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        modulus_shadow = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_reset_modulus();
        send_operands(32'h0, 32'h0);
        send_operands(32'h0, 32'h1);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'h0);
        send_operands(32'h1, 32'hFFFF_FFFF);
        send_operands(32'h2, 32'd10);
        send_operands(32'd1000000007, 32'd5);   // base reduces to zero
        send_operands(32'd1000000006, 32'd2);
        send_operands(32'h3, 32'h8000_0000);
        send_operands(32'h5555_5555, 32'hAAAA_AAAA);
        send_operands(32'hAAAA_AAAA, 32'h5555_5555);
        wait_results();
    endtask

    task automatic test_modulus_extremes();
        // modulus one: zero exponent still gives one, anything else zero
        write_modulus(CFG_W'(1));
        send_operands(32'h7, 32'h0);
        send_operands(32'h7, 32'h1);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_modulus(CFG_W'(2));
        send_operands(32'hFFFF_FFFF, 32'h3);
        send_operands(32'h2, 32'h1);
        write_modulus(MODULUS_MAX);
        send_operands(32'h7FFF_FFFE, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'h2);
        // zero modulus wraps at the full register width
        write_modulus('0);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'h8000_0001, 32'h3);
        wait_results();
    endtask

    task automatic test_random_operands();
        logic [CFG_W-1:0] settings[6];
        settings[0] = CFG_W'($urandom_range(2, 32'h7FFF_FFFF));
        settings[1] = MODULUS_MAX;
        settings[2] = CFG_W'($urandom_range(2, 1000));
        settings[3] = CFG_W'(1);
        settings[4] = '0;
        settings[5] = MODULUS_RESET;
        foreach (settings[s]) begin
            write_modulus(settings[s]);
            repeat (36) send_operands(pick_base(), pick_exponent());
        end
        wait_results();
    endtask

    // hold the output off long enough that the block fills and stalls its input
    task automatic test_backpressure();
        write_modulus(CFG_W'($urandom_range(2, 32'h7FFF_FFFF)));
        hold_cycles = 3000;
        repeat (4) send_operands($urandom, EXP_W'($urandom_range(1, 255)));
        wait_results();
    endtask

    task automatic test_back_to_back();
        idling_on = 1'b0;
        write_modulus(CFG_W'($urandom_range(2, 32'h7FFF_FFFF)));
        repeat (30) send_operands(pick_base(), pick_exponent());
        wait_results();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_modulus = '0;
        i_in_valid    = 1'b0;
        i_base        = '0;
        i_exponent    = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_modulus();
        test_modulus_extremes();
        test_random_operands();
        test_backpressure();
        test_back_to_back();

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_powers.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/modular_exponentiation.sv
verif/modular_exponentiation_tb.sv
